[hdl/mclw_pkg.sv]
// shared types and constants for the multi-channel link loss watchdog
// no dependencies; imported by the channel ram, the top level, the checker and the testbench
`default_nettype none

package mclw_pkg;

    // fixed field widths
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned CNT_W     = 10;
    localparam int unsigned PHASE_W   = 5;
    localparam int unsigned FLAGS_W   = 6;
    localparam int unsigned CFG_IDX_W = 3;

    // register file layout
    localparam int unsigned NUM_SLOTS     = 6;
    localparam int unsigned CHANNELS_DEF  = 6;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 3'd6;

    // reset values and limits
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd100;
    localparam logic [CNT_W-1:0]   CONFIRM_RESET = 10'd500;
    localparam logic [CNT_W-1:0]   COUNT_MAX     = 10'd1023;
    localparam logic [PHASE_W-1:0] HEART_HALF    = 5'd10;
    localparam logic [PHASE_W-1:0] HEART_PERIOD  = 5'd20;

    // command codes
    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_FEED = 2'd1,
        FUNC_SCAN = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    // one channel entry held in the channel ram
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [CNT_W-1:0]  count;
    } t_chan_entry;

endpackage

`default_nettype wire

[hdl/mclw_chan_ram.sv]
// per-channel state ram: feed stamp and over-time count, one read and one write port
// read data registered; entries never written read as zero via valid bits
`default_nettype none

module mclw_chan_ram
    import mclw_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF,
    parameter int unsigned AW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic        i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_chan_entry i_wr_data,
    output t_chan_entry      o_rd_data
);

    t_chan_entry         r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_valid;
    t_chan_entry         r_rd_data;
    logic                r_rd_valid;

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // written-entry bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // unwritten entries read as reset value
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

[hdl/multi_channel_link_loss_watchdog.sv]
// top level of the link loss watchdog: command sequencer, config registers, heartbeat
// uses mclw_pkg and mclw_chan_ram
//
//  port group   direction  handshake           contents
//  command      in         start / busy        i_func, i_channel
//  result       out        o_valid (strobe)    o_lost_flags, o_led_a, o_led_b
//  config       in         i_cfg_we            i_cfg_index, i_cfg_data
//
// tick, unused codes and feeds past the last channel need no ram access, result strobe next cycle.
// feed reads then writes the channel entry in the ram.
// scan: one ram entry read-modify-written per cycle, the next read overlapping the
// current write, as the ram has a single read and write port pair.
// reset is synchronous, no clearing pass; results cannot be stalled.
`default_nettype none

module multi_channel_link_loss_watchdog
    import mclw_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_func,
    input  wire logic [2:0]           i_channel,
    output logic                      o_valid,
    output logic [FLAGS_W-1:0]        o_lost_flags,
    output logic                      o_led_a,
    output logic                      o_led_b,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TMO_W-1:0]     i_cfg_data
);

    localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_FEED = 3'b010,
        S_SCAN = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_idx, n_idx;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [CHANNELS-1:0] r_lost, n_lost;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic                r_led_a, n_led_a;
    logic                r_led_b, n_led_b;
    logic                r_valid, n_valid;
    logic [TMO_W-1:0]    r_timeout [CHANNELS];
    logic [CNT_W-1:0]    r_confirm;

    logic                accept;
    t_func               func;
    logic                feed_ok;
    logic                last_ch;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_chan_entry         wr_data;
    t_chan_entry         rd_data;

    // scan datapath
    logic                ahead;
    logic [TIME_W-1:0]   stamp_fix;
    logic [TIME_W-1:0]   elapsed;
    logic                over;
    logic [CNT_W-1:0]    cnt_inc;
    logic                confirm_hit;
    logic [PHASE_W-1:0]  phase_inc;

    assign accept  = start && !busy;
    assign func    = t_func'(i_func);
    assign feed_ok = i_channel < 3'(CHANNELS);
    assign last_ch = r_idx == AW'(CHANNELS - 1);

    // channel state ram
    mclw_chan_ram #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_chan_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    // per-channel check on the entry just read
    assign ahead       = rd_data.stamp > r_time;
    assign stamp_fix   = ahead ? (r_time - 32'd1) : rd_data.stamp;
    assign elapsed     = ahead ? 32'd1 : (r_time - rd_data.stamp);
    assign over        = elapsed > TIME_W'(r_timeout[r_idx]);
    assign cnt_inc     = (rd_data.count < COUNT_MAX) ? (rd_data.count + 10'd1)
                                                     : rd_data.count;
    assign confirm_hit = cnt_inc > r_confirm;
    assign phase_inc   = r_phase + 5'd1;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_time  = r_time;
        n_lost  = r_lost;
        n_phase = r_phase;
        n_led_a = r_led_a;
        n_led_b = r_led_b;
        n_valid = 1'b0;
        rd_en   = 1'b0;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = rd_data;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (func)
                        FUNC_TICK: begin
                            n_time  = r_time + 32'd1;
                            n_valid = 1'b1;
                        end
                        FUNC_FEED: begin
                            if (feed_ok) begin
                                rd_en   = 1'b1;
                                rd_addr = i_channel[AW-1:0];
                                n_idx   = i_channel[AW-1:0];
                                n_state = S_FEED;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        FUNC_SCAN: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        FUNC_NONE: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_FEED: begin
                // restamp, keep the count
                wr_en         = 1'b1;
                wr_data.stamp = r_time;
                wr_data.count = rd_data.count;
                n_valid       = 1'b1;
                n_state       = S_IDLE;
            end
            S_SCAN: begin
                wr_en         = 1'b1;
                wr_data.stamp = stamp_fix;
                if (over) begin
                    if (confirm_hit) begin
                        wr_data.count = '0;
                        n_lost[r_idx] = 1'b1;
                    end else begin
                        wr_data.count = cnt_inc;
                    end
                end else begin
                    wr_data.count = '0;
                    n_lost[r_idx] = 1'b0;
                end
                if (last_ch) begin
                    // heartbeat after the last channel
                    n_phase = (phase_inc >= HEART_PERIOD) ? '0 : phase_inc;
                    if (n_phase == HEART_HALF) begin
                        n_led_a = 1'b1;
                        n_led_b = 1'b0;
                    end else if (n_phase == '0) begin
                        n_led_a = 1'b0;
                        n_led_b = 1'b1;
                    end
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // overlap next read with this write
                    rd_en   = 1'b1;
                    rd_addr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_time  <= '0;
            r_lost  <= '0;
            r_phase <= '0;
            r_led_a <= 1'b0;
            r_led_b <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_time  <= n_time;
            r_lost  <= n_lost;
            r_phase <= n_phase;
            r_led_a <= n_led_a;
            r_led_b <= n_led_b;
            r_valid <= n_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_timeout[c] <= TIMEOUT_RESET;
            end
            r_confirm <= CONFIRM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index < CFG_IDX_W'(CHANNELS)) begin
                r_timeout[i_cfg_index[AW-1:0]] <= i_cfg_data;
            end else if (i_cfg_index == REG_CONFIRM) begin
                r_confirm <= i_cfg_data[CNT_W-1:0];
            end
        end
    end

    // result beat
    assign busy         = r_state != S_IDLE;
    assign o_valid      = r_valid;
    assign o_lost_flags = FLAGS_W'(r_lost);
    assign o_led_a      = r_led_a;
    assign o_led_b      = r_led_b;

endmodule

`default_nettype wire

[test/mclw_link_checker.sv]
// result checker for the multi-channel link loss watchdog: tracks channel state, predicts
// the status of every accepted command and compares it with each result beat
// uses mclw_pkg; instantiated by the testbench next to the block
`default_nettype none

module mclw_link_checker
    import mclw_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_busy,
    input  wire logic [1:0]           i_func,
    input  wire logic [2:0]           i_channel,
    input  wire logic                 i_valid,
    input  wire logic [FLAGS_W-1:0]   i_lost_flags,
    input  wire logic                 i_led_a,
    input  wire logic                 i_led_b,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TMO_W-1:0]     i_cfg_data,
    output int                        o_mismatches,
    output int                        o_pending
);

    typedef struct packed {
        logic [FLAGS_W-1:0] flags;
        logic               led_a;
        logic               led_b;
    } t_link_status;

    // statuses still owed by the block, oldest first
    t_link_status status_q[$];

    // tracked channel state and register copies
    logic [TIME_W-1:0]    now_ticks;
    logic [TIME_W-1:0]    stamp_m   [NUM_SLOTS];
    logic [CNT_W-1:0]     over_m    [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] lost_m;
    logic [PHASE_W-1:0]   heart_phase;
    logic                 led_a_m;
    logic                 led_b_m;
    logic [TMO_W-1:0]     timeout_m [NUM_SLOTS];
    logic [CNT_W-1:0]     confirm_m;
    int                   mismatches = 0;

    function automatic void clear_state();
        for (int c = 0; c < NUM_SLOTS; c++) begin
            stamp_m[c]   = '0;
            over_m[c]    = '0;
            timeout_m[c] = TIMEOUT_RESET;
        end
        lost_m      = '0;
        now_ticks   = '0;
        heart_phase = '0;
        led_a_m     = 1'b0;
        led_b_m     = 1'b0;
        confirm_m   = CONFIRM_RESET;
    endfunction

    // walk every channel, then step the heartbeat
    function automatic void scan_channels();
        logic [TIME_W-1:0] elapsed;
        for (int c = 0; c < CHANNELS && c < NUM_SLOTS; c++) begin
            // a stamp ahead of now is pulled back to just behind now
            if (stamp_m[c] > now_ticks)
                stamp_m[c] = now_ticks - 1'b1;
            elapsed = now_ticks - stamp_m[c];
            if (elapsed > TIME_W'(timeout_m[c])) begin
                if (over_m[c] != COUNT_MAX)
                    over_m[c] = over_m[c] + 1'b1;
                if (over_m[c] > confirm_m) begin
                    over_m[c] = '0;
                    lost_m[c] = 1'b1;
                end
            end else begin
                over_m[c] = '0;
                lost_m[c] = 1'b0;
            end
        end
        if (heart_phase >= HEART_PERIOD - 1'b1)
            heart_phase = '0;
        else
            heart_phase = heart_phase + 1'b1;
        if (heart_phase == HEART_HALF) begin
            led_a_m = 1'b1;
            led_b_m = 1'b0;
        end else if (heart_phase == '0) begin
            led_a_m = 1'b0;
            led_b_m = 1'b1;
        end
    endfunction

    // apply one command and return the status it answers with
    function automatic t_link_status predict_status(input t_func f, input logic [2:0] ch);
        t_link_status s;
        case (f)
            FUNC_TICK: now_ticks = now_ticks + 1'b1;
            FUNC_FEED: begin
                if (ch < CHANNELS && ch < NUM_SLOTS)
                    stamp_m[ch] = now_ticks;
            end
            FUNC_SCAN: scan_channels();
            default: ;
        endcase
        s.flags = FLAGS_W'(lost_m);
        s.led_a = led_a_m;
        s.led_b = led_b_m;
        return s;
    endfunction

    // result check first, then register writes, then the accepted command
    always @(posedge i_clk) begin : check_proc
        t_link_status oldest;
        if (!i_rst_n) begin
            clear_state();
            status_q.delete();
        end else begin
            if (i_valid) begin
                if (status_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected status beat: flags %b led_a %b led_b %b",
                                 i_lost_flags, i_led_a, i_led_b);
                end else begin
                    oldest = status_q.pop_front();
                    if (i_lost_flags !== oldest.flags || i_led_a !== oldest.led_a ||
                        i_led_b !== oldest.led_b) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("status beat wrong: exp flags %b leds %b%b, got %b %b%b",
                                     oldest.flags, oldest.led_a, oldest.led_b,
                                     i_lost_flags, i_led_a, i_led_b);
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index < NUM_SLOTS)
                    timeout_m[i_cfg_index] = i_cfg_data;
                else if (i_cfg_index == REG_CONFIRM)
                    confirm_m = i_cfg_data[CNT_W-1:0];
            end
            if (i_start && !i_busy)
                status_q.push_back(predict_status(t_func'(i_func), i_channel));
        end
        o_pending    <= status_q.size();
        o_mismatches <= mismatches;
    end

endmodule

`default_nettype wire

[test/testbench.sv]
// top of the link loss watchdog testbench: clock, reset, command and register stimulus
// uses mclw_pkg, the block and mclw_link_checker, which does all result checking
`default_nettype none

module testbench
    import mclw_pkg::*;
;

    localparam int STALL_LIMIT   = 600;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic [1:0]           i_func      = '0;
    logic [2:0]           i_channel   = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TMO_W-1:0]     i_cfg_data  = '0;
    wire logic                busy;
    wire logic                o_valid;
    wire logic [FLAGS_W-1:0]  o_lost_flags;
    wire logic                o_led_a;
    wire logic                o_led_b;

    int mismatch_count;
    int pending_count;
    int idle_pct   = 0;
    int quiet_cycles = 0;

    // register values for the next setting
    logic [TMO_W-1:0] plan_timeout [NUM_SLOTS];
    logic [TMO_W-1:0] plan_confirm;

    always #2 i_clk = ~i_clk;

    multi_channel_link_loss_watchdog dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_channel    (i_channel),
        .o_valid      (o_valid),
        .o_lost_flags (o_lost_flags),
        .o_led_a      (o_led_a),
        .o_led_b      (o_led_b),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    mclw_link_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_func       (i_func),
        .i_channel    (i_channel),
        .i_valid      (o_valid),
        .i_lost_flags (o_lost_flags),
        .i_led_a      (o_led_a),
        .i_led_b      (o_led_b),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_count)
    );

    // hang detection: cycles with no command, result or register beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("multi_channel_link_loss_watchdog: mismatch");
            $finish;
        end
    end

    // one command beat, with an optional gap in front of it
    task automatic send_cmd(input t_func f, input logic [2:0] ch);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_func    <= f;
        i_channel <= ch;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // hold off until every status has come back and the block is quiet
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the planned setting, plus one write to the unused index
    task automatic program_regs();
        for (int r = 0; r < NUM_SLOTS; r++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= REG_TIMEOUT0 + CFG_IDX_W'(r);
            i_cfg_data  <= plan_timeout[r];
            @(posedge i_clk);
        end
        i_cfg_index <= REG_CONFIRM;
        i_cfg_data  <= plan_confirm;
        @(posedge i_clk);
        i_cfg_index <= REG_SPARE;
        i_cfg_data  <= TMO_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly ticks, feeds and scans with random content, a few odd commands
    task automatic run_phase(input int count, input int pct);
        int          pick;
        logic [2:0]  ch;
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(59) == 0)
                settle();
            pick = $urandom_range(99);
            ch   = 3'($urandom_range(0, 7));
            if (pick < 40) begin
                send_cmd(FUNC_TICK, ch);
            end else if (pick < 62) begin
                if ($urandom_range(9) != 0)
                    ch = 3'($urandom_range(0, CHANNELS_DEF - 1));
                send_cmd(FUNC_FEED, ch);
            end else if (pick < 95) begin
                send_cmd(FUNC_SCAN, ch);
            end else begin
                send_cmd(FUNC_NONE, ch);
            end
        end
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // status under reset register values
        send_cmd(FUNC_SCAN, 3'd0);
        settle();

        // zero and full timeouts, immediate confirm
        plan_timeout = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd4};
        plan_confirm = 16'd0;
        program_regs();
        send_cmd(FUNC_SCAN, 3'd0);
        send_cmd(FUNC_TICK, 3'd7);
        send_cmd(FUNC_SCAN, 3'd0);
        send_cmd(FUNC_TICK, 3'd0);
        send_cmd(FUNC_TICK, 3'd5);
        send_cmd(FUNC_SCAN, 3'd2);
        send_cmd(FUNC_FEED, 3'd0);
        send_cmd(FUNC_FEED, 3'd5);
        // feeds past the last channel are dropped
        send_cmd(FUNC_FEED, 3'd6);
        send_cmd(FUNC_FEED, 3'd7);
        send_cmd(FUNC_NONE, 3'd7);
        send_cmd(FUNC_SCAN, 3'd0);
        send_cmd(FUNC_TICK, 3'd0);
        send_cmd(FUNC_TICK, 3'd0);
        send_cmd(FUNC_TICK, 3'd0);
        send_cmd(FUNC_SCAN, 3'd0);
        send_cmd(FUNC_FEED, 3'd1);
        send_cmd(FUNC_FEED, 3'd2);
        send_cmd(FUNC_SCAN, 3'd0);
        send_cmd(FUNC_NONE, 3'd0);
        send_cmd(FUNC_SCAN, 3'd0);
        settle();

        // short timeouts so channels drop out and come back often
        for (int r = 0; r < NUM_SLOTS; r++)
            plan_timeout[r] = TMO_W'($urandom_range(0, 20));
        plan_confirm = TMO_W'($urandom_range(0, 4));
        program_regs();
        run_phase(210, 33);

        // extreme timeouts; upper data bits above the confirm field are dropped
        plan_timeout[0] = 16'd0;
        plan_timeout[1] = 16'hFFFF;
        for (int r = 2; r < NUM_SLOTS; r++)
            plan_timeout[r] = TMO_W'($urandom_range(0, 40));
        plan_confirm = 16'hFC01;
        program_regs();
        run_phase(105, 46);

        // full-range timeouts with the largest confirm count
        for (int r = 0; r < NUM_SLOTS; r++)
            plan_timeout[r] = (r % 2 == 0) ? TMO_W'($urandom) : TMO_W'($urandom_range(0, 8));
        plan_confirm = 16'hFFFF;
        program_regs();
        run_phase(105, 46);

        // back-to-back commands, no sender gaps
        for (int r = 0; r < NUM_SLOTS; r++)
            plan_timeout[r] = TMO_W'($urandom_range(0, 24));
        plan_confirm = {6'($urandom), 10'($urandom_range(0, 3))};
        program_regs();
        run_phase(210, 0);

        if (mismatch_count == 0 && pending_count == 0)
            $display("multi_channel_link_loss_watchdog: match");
        else
            $display("multi_channel_link_loss_watchdog: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
hdl/mclw_pkg.sv
hdl/mclw_chan_ram.sv
hdl/multi_channel_link_loss_watchdog.sv
test/mclw_link_checker.sv
test/testbench.sv
